### rtl/core/complementarity_gap_reduce_top_macros.svh
// assertion macros of the complementarity gap reduction rtl, used by cgr_ctrl
// expects clk_i and rst_ni in the scope of use
`ifndef COMPLEMENTARITY_GAP_REDUCE_TOP_MACROS_SVH
`define COMPLEMENTARITY_GAP_REDUCE_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define CGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/cgr_pkg.sv
// shared types, constants and helper functions of the complementarity gap block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cgr_pkg;

  // rounding word width
  localparam int MW = 108;

  localparam logic [1:0] KIND_BOTH  = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  localparam logic [63:0] DBL_ONE    = 64'h3FF0_0000_0000_0000;
  localparam logic [62:0] DBL_INF_MAG = 63'h7FF0_0000_0000_0000;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_UNPACK,
    OP_MUL_PP,
    OP_MUL_LAST,
    OP_LZC,
    OP_LSHIFT,
    OP_RSHIFT,
    OP_PACK,
    OP_ADD_ALIGN,
    OP_ADD_SUM,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       upper;   // operand pair: upper bound when set
    logic [1:0] pp_idx;  // partial product index
    logic       to_gap;  // pack result goes to the running gap
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
  } stat_t;

  // leading zero count of the rounding word, MW when zero
  function automatic logic [6:0] lzc(input logic [MW-1:0] v);
    logic [6:0] r;
    r = 7'(MW);
    for (int i = 0; i < MW; i++) begin
      if (v[i]) r = 7'(MW - 1 - i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cgr_ctrl.sv
// sequencing state machine of the complementarity gap block
// depends on cgr_pkg and the macro header
`timescale 1ns / 1ps
`default_nettype none
`include "complementarity_gap_reduce_top_macros.svh"

module cgr_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            accept_i,
  input  cgr_pkg::stat_t stat_i,
  input  wire            out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output cgr_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHOOSE, S_UNPACK, S_PP, S_LZC, S_LSH, S_RSH, S_PACK,
    S_ALIGN, S_SUM, S_DONE, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic       ready_q, ready_d;
  logic       oval_q, oval_d;
  logic       upper_q, upper_d;
  logic       add_q, add_d;
  logic [2:0] cnt_q, cnt_d;
  logic       want;

  // does the current bound exist for this variable
  assign want = upper_q ? (stat_i.kind == cgr_pkg::KIND_BOTH ||
                           stat_i.kind == cgr_pkg::KIND_UPPER)
                        : (stat_i.kind == cgr_pkg::KIND_BOTH ||
                           stat_i.kind == cgr_pkg::KIND_LOWER);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    oval_d  = oval_q & ~out_ready_i;
    upper_d = upper_q;
    add_d   = add_q;
    cnt_d   = cnt_q;
    cmd_o   = '{op: cgr_pkg::OP_NONE, upper: upper_q, pp_idx: cnt_q[1:0], to_gap: add_q};
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          ready_d = 1'b0;
          upper_d = 1'b0;
          state_d = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        if (want) begin
          state_d = S_UNPACK;
        end else if (!upper_q) begin
          upper_d = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UNPACK: begin
        cmd_o.op = cgr_pkg::OP_UNPACK;
        cnt_d    = 3'd0;
        state_d  = S_PP;
      end
      S_PP: begin
        if (cnt_q == 3'd4) begin
          cmd_o.op = cgr_pkg::OP_MUL_LAST;
          add_d    = 1'b0;
          state_d  = S_LZC;
        end else begin
          cmd_o.op = cgr_pkg::OP_MUL_PP;
          cnt_d    = cnt_q + 3'd1;
        end
      end
      S_LZC: begin
        cmd_o.op = cgr_pkg::OP_LZC;
        state_d  = S_LSH;
      end
      S_LSH: begin
        cmd_o.op = cgr_pkg::OP_LSHIFT;
        state_d  = S_RSH;
      end
      S_RSH: begin
        cmd_o.op = cgr_pkg::OP_RSHIFT;
        state_d  = S_PACK;
      end
      S_PACK: begin
        cmd_o.op = cgr_pkg::OP_PACK;
        if (!add_q) begin
          state_d = S_ALIGN;
        end else begin
          upper_d = 1'b1;
          state_d = upper_q ? S_DONE : S_CHOOSE;
        end
      end
      S_ALIGN: begin
        cmd_o.op = cgr_pkg::OP_ADD_ALIGN;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = cgr_pkg::OP_ADD_SUM;
        add_d    = 1'b1;
        state_d  = S_LZC;
      end
      S_DONE: begin
        if (stat_i.last) begin
          state_d = S_EMIT;
        end else begin
          ready_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.op = cgr_pkg::OP_EMIT;
          oval_d   = 1'b1;
          ready_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      oval_q  <= 1'b0;
      upper_q <= 1'b0;
      add_q   <= 1'b0;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      oval_q  <= oval_d;
      upper_q <= upper_d;
      add_q   <= add_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = oval_q;

  `CGR_ASSERT(a_one_item, accept_i |=> !ready_q, "second request taken while busy")
  `CGR_ASSERT(a_emit_last, (cmd_o.op == cgr_pkg::OP_EMIT) |-> stat_i.last,
              "result emitted for an item not marked last")
  `CGR_ASSERT(a_pp_range, (state_q == S_PP) |-> (cnt_q <= 3'd4),
              "partial product counter out of range")
  `CGR_ASSERT(a_ready_idle, ready_q |-> (state_q == S_IDLE),
              "ready raised outside idle")

endmodule

`default_nettype wire

### rtl/core/cgr_dpath.sv
// double multiply, accumulate, rounding and result registers
// depends on cgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cgr_dpath (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  cgr_pkg::cmd_t  cmd_i,
  input  wire            accept_i,
  input  wire  [255:0]   item_data_i,
  input  wire  [1:0]     item_kind_i,
  input  wire            item_last_i,
  input  wire            cfg_valid_i,
  input  wire  [62:0]    cfg_data_i,
  output cgr_pkg::stat_t stat_o,
  output logic [127:0]   out_data_o
);

  localparam int MW = cgr_pkg::MW;

  // item and configuration
  logic [63:0] ld_q, ls_q, ud_q, us_q;
  logic [1:0]  kind_q;
  logic        last_q;
  logic [62:0] thr_q;

  // multiplier
  logic [52:0]        am_q, bm_q;
  logic               msgn_q;
  logic signed [13:0] mexp_q;
  logic               mspec_q;
  logic [53:0]        pp_q;
  logic [5:0]         pp_sh_q;
  logic [105:0]       acc_q;

  // adder
  logic [56:0]        amb_q, ams_q;
  logic signed [13:0] aeb_q;
  logic               asb_q, ass_q, aspec_q;

  // rounding
  logic [MW-1:0]      rnd_m_q, n_q;
  logic signed [13:0] rnd_e_q, bexp_q;
  logic               rnd_s_q, rnd_spec_q, ovf_q;
  logic [6:0]         lz_q;
  logic [10:0]        efield_q;

  // results
  logic [63:0] prod_q, gap_q, gout_q;
  logic [62:0] worst_q, wout_q;
  logic        nopt_q;

  // operand unpack
  logic [63:0]        opa, opb;
  logic [52:0]        ma, mb;
  logic signed [13:0] ea, eb;
  logic               infab;

  assign opa   = cmd_i.upper ? ud_q : ld_q;
  assign opb   = cmd_i.upper ? us_q : ls_q;
  assign ma    = {|opa[62:52], opa[51:0]};
  assign mb    = {|opb[62:52], opb[51:0]};
  assign ea    = $signed({3'b0, (opa[62:52] == 11'd0) ? 11'd1 : opa[62:52]}) - 14'sd1075;
  assign eb    = $signed({3'b0, (opb[62:52] == 11'd0) ? 11'd1 : opb[62:52]}) - 14'sd1075;
  assign infab = (&opa[62:52]) | (&opb[62:52]);

  // partial product select
  logic [26:0] pa, pb;
  logic [53:0] pp_d;
  logic [5:0]  psh_d;
  logic [105:0] acc_sum;

  always_comb begin
    pa    = am_q[26:0];
    pb    = bm_q[26:0];
    psh_d = 6'd0;
    case (cmd_i.pp_idx)
      2'd0: begin pa = am_q[26:0];          pb = bm_q[26:0];          psh_d = 6'd0;  end
      2'd1: begin pa = am_q[26:0];          pb = {1'b0, bm_q[52:27]}; psh_d = 6'd27; end
      2'd2: begin pa = {1'b0, am_q[52:27]}; pb = bm_q[26:0];          psh_d = 6'd27; end
      2'd3: begin pa = {1'b0, am_q[52:27]}; pb = {1'b0, bm_q[52:27]}; psh_d = 6'd54; end
      default: psh_d = 6'd0;
    endcase
  end

  assign pp_d    = pa * pb;
  assign acc_sum = acc_q + ({52'd0, pp_q} << pp_sh_q);

  // add alignment
  logic               swap;
  logic [63:0]        bigv, smlv;
  logic [52:0]        mbig, msml;
  logic signed [13:0] ebig, esml, dexp;
  logic [56:0]        ms57, mshift;
  logic               stk;

  assign swap = prod_q[62:0] > gap_q[62:0];
  assign bigv = swap ? prod_q : gap_q;
  assign smlv = swap ? gap_q : prod_q;
  assign mbig = {|bigv[62:52], bigv[51:0]};
  assign msml = {|smlv[62:52], smlv[51:0]};
  assign ebig = $signed({3'b0, (bigv[62:52] == 11'd0) ? 11'd1 : bigv[62:52]}) - 14'sd1075;
  assign esml = $signed({3'b0, (smlv[62:52] == 11'd0) ? 11'd1 : smlv[62:52]}) - 14'sd1075;
  assign dexp = ebig - esml;
  assign ms57 = {1'b0, msml, 3'b000};

  always_comb begin
    if (dexp >= 14'sd57) begin
      mshift = '0;
      stk    = |msml;
    end else begin
      mshift = ms57 >> dexp[5:0];
      stk    = |(ms57 & ~({57{1'b1}} << dexp[5:0]));
    end
  end

  // add core
  logic [57:0] sum58;
  assign sum58 = (asb_q ^ ass_q) ? ({1'b0, amb_q} - {1'b0, ams_q})
                                 : ({1'b0, amb_q} + {1'b0, ams_q});

  // subnormal right shift with sticky
  logic signed [13:0] rsh;
  logic [6:0]         rshc;
  logic [MW-1:0]      nrs;
  assign rsh  = 14'sd1 - bexp_q;
  assign rshc = (rsh > 14'sd108) ? 7'(MW) : rsh[6:0];
  assign nrs  = (n_q >> rshc) | {{(MW-1){1'b0}}, |(n_q & ~({MW{1'b1}} << rshc))};

  // round to nearest even and pack
  logic [52:0] kept;
  logic        inc;
  logic [62:0] pk, mag;
  assign kept = n_q[MW-1:MW-53];
  assign inc  = n_q[MW-54] & ((|n_q[MW-55:0]) | kept[0]);
  assign pk   = {efield_q, kept[51:0]} + {62'd0, inc};

  always_comb begin
    if (rnd_spec_q)           mag = cgr_pkg::DBL_INF_MAG;
    else if (rnd_m_q == '0)   mag = '0;
    else if (ovf_q)           mag = cgr_pkg::DBL_INF_MAG;
    else                      mag = pk;
  end

  // configuration and control-bearing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      gap_q   <= '0;
      worst_q <= '0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (cmd_i.op == cgr_pkg::OP_PACK) begin
        if (cmd_i.to_gap) begin
          gap_q <= {rnd_s_q, mag};
        end else if (mag > thr_q && mag > worst_q) begin
          worst_q <= mag;
        end
      end
      if (cmd_i.op == cgr_pkg::OP_EMIT) begin
        gap_q   <= '0;
        worst_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ld_q   <= item_data_i[63:0];
      ls_q   <= item_data_i[127:64];
      ud_q   <= item_data_i[191:128];
      us_q   <= item_data_i[255:192];
      kind_q <= item_kind_i;
      last_q <= item_last_i;
    end
    case (cmd_i.op)
      cgr_pkg::OP_UNPACK: begin
        am_q    <= ma;
        bm_q    <= mb;
        msgn_q  <= opa[63] ^ opb[63];
        mexp_q  <= ea + eb;
        mspec_q <= infab;
        pp_q    <= '0;
        pp_sh_q <= '0;
        acc_q   <= '0;
      end
      cgr_pkg::OP_MUL_PP: begin
        pp_q    <= pp_d;
        pp_sh_q <= psh_d;
        acc_q   <= acc_sum;
      end
      cgr_pkg::OP_MUL_LAST: begin
        rnd_m_q    <= {2'b00, acc_sum};
        rnd_e_q    <= mexp_q;
        rnd_s_q    <= msgn_q;
        rnd_spec_q <= mspec_q;
      end
      cgr_pkg::OP_LZC: begin
        lz_q <= cgr_pkg::lzc(rnd_m_q);
      end
      cgr_pkg::OP_LSHIFT: begin
        n_q    <= rnd_m_q << lz_q;
        bexp_q <= rnd_e_q + 14'sd1130 - $signed({7'd0, lz_q});
      end
      cgr_pkg::OP_RSHIFT: begin
        if (bexp_q < 14'sd1) begin
          n_q      <= nrs;
          efield_q <= '0;
          ovf_q    <= 1'b0;
        end else begin
          efield_q <= bexp_q[10:0];
          ovf_q    <= bexp_q >= 14'sd2047;
        end
      end
      cgr_pkg::OP_PACK: begin
        if (!cmd_i.to_gap) prod_q <= {rnd_s_q, mag};
      end
      cgr_pkg::OP_ADD_ALIGN: begin
        amb_q   <= {1'b0, mbig, 3'b000};
        ams_q   <= mshift | {56'd0, stk};
        aeb_q   <= ebig;
        asb_q   <= bigv[63];
        ass_q   <= smlv[63];
        aspec_q <= &bigv[62:52];
      end
      cgr_pkg::OP_ADD_SUM: begin
        rnd_m_q    <= {50'd0, sum58};
        rnd_e_q    <= aeb_q - 14'sd3;
        rnd_s_q    <= (sum58 == '0) ? (asb_q & ass_q) : asb_q;
        rnd_spec_q <= aspec_q;
      end
      cgr_pkg::OP_EMIT: begin
        gout_q <= (gap_q[62:0] == '0) ? cgr_pkg::DBL_ONE : gap_q;
        wout_q <= worst_q;
        nopt_q <= worst_q > thr_q;
      end
      default: ;
    endcase
  end

  assign stat_o     = '{kind: kind_q, last: last_q};
  assign out_data_o = {nopt_q, wout_q, gout_q};

endmodule

`default_nettype wire

### rtl/core/complementarity_gap_reduce_top.sv
// top level of the complementarity gap reduction block
// depends on cgr_pkg, cgr_ctrl and cgr_dpath
//
// channel   dir  handshake                    content
// s_axis    in   s_axis_tvalid/s_axis_tready  one variable: bounds, distances, slacks
// m_axis    out  m_axis_tvalid/m_axis_tready  gap total, worst violation, flag
// cfg       in   cfg_valid_i/cfg_ready_o      optimality threshold
//
// each product of an item runs through an unpack step, 5 multiply steps
// over 27x27 partial products, 4 rounding steps, 2 add steps, 4 more rounding steps;
// the single shared multiply/round/add sequence handles one item at a time, so a
// new request is taken only after the previous item is through.
// the last item of a run also loads the output register, and is held while
// the previous result still waits there.
// reset clears sums, threshold and handshake state; no clearing pass.
// a stalled result waits in the output register while the next run proceeds.
`timescale 1ns / 1ps
`default_nettype none

module complementarity_gap_reduce_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // lower_distance, lower_slack, upper_distance, upper_slack
  input  wire  [255:0] s_axis_tdata,
  // bound_kind
  input  wire  [1:0]   s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // gap_total, worst_violation, not_optimal
  output logic [127:0] m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [62:0]  cfg_data_i
);

  cgr_pkg::cmd_t  cmd;
  cgr_pkg::stat_t stat;
  logic           accept;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // sequencer
  cgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .stat_i      (stat),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // arithmetic
  cgr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .accept_i    (accept),
    .item_data_i (s_axis_tdata),
    .item_kind_i (s_axis_tuser),
    .item_last_i (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### bench/tb_complementarity_gap_reduce_top.sv
// self-checking bench for the complementarity gap reduction top level
// depends on cgr_pkg and complementarity_gap_reduce_top; uses simulator reals as binary64
`timescale 1ns / 1ps
`default_nettype none

module tb_complementarity_gap_reduce_top;

  localparam logic [1:0]  KIND_NONE = 2'd3;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam int          DRAIN_CYC = 40;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] lo_dist;
    logic [63:0] lo_slack;
    logic [63:0] up_dist;
    logic [63:0] up_slack;
    logic        last;
  } var_req_t;

  typedef struct {
    logic [63:0] gap;
    logic [62:0] worst;
    logic        flag;
  } gap_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [62:0]  cfg_data_i = '0;

  var_req_t    pending_vars[$];
  gap_res_t    expected_gaps[$];
  logic [62:0] thr_bits = '0;
  real         gap_sum = 0.0;
  real         worst_mag = 0.0;
  int          mismatches = 0;
  int          s_idle = 0;
  int          m_idle = 0;
  bit          quiet = 1'b0;

  complementarity_gap_reduce_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one rounded product folded into the sums, worst magnitude first
  function automatic void fold_product(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] pb;
    real         p;
    real         mag;
    real         thr;
    p   = $bitstoreal(a) * $bitstoreal(b);
    pb  = $realtobits(p);
    mag = $bitstoreal(pb & ~SIGN_BIT);
    thr = $bitstoreal({1'b0, thr_bits});
    if (mag > thr && mag > worst_mag) worst_mag = mag;
    gap_sum = gap_sum + p;
  endfunction

  // expected gap result for one accepted variable
  function automatic void predict_gap(input var_req_t v);
    gap_res_t r;
    real      g;
    logic [63:0] wb;
    if (v.kind == cgr_pkg::KIND_BOTH || v.kind == cgr_pkg::KIND_LOWER)
      fold_product(v.lo_dist, v.lo_slack);
    if (v.kind == cgr_pkg::KIND_BOTH || v.kind == cgr_pkg::KIND_UPPER)
      fold_product(v.up_dist, v.up_slack);
    if (v.last) begin
      g = gap_sum;
      if (g == 0.0) g = 1.0;
      wb      = $realtobits(worst_mag);
      r.gap   = $realtobits(g);
      r.worst = wb[62:0];
      r.flag  = worst_mag > $bitstoreal({1'b0, thr_bits});
      expected_gaps.push_back(r);
      gap_sum   = 0.0;
      worst_mag = 0.0;
    end
  endfunction

  // random double, mostly moderate exponents, never nan or infinity
  function automatic logic [63:0] rand_dbl();
    logic [63:0] d;
    int          sel;
    sel = $urandom_range(0, 99);
    d   = {$urandom, $urandom};
    if (sel < 60)      d[62:52] = 11'($urandom_range(12'h3E0, 12'h420));
    else if (sel < 72) d = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
    else if (sel < 84) d[62:52] = 11'($urandom_range(0, 12'h7FE));
    else               d[62:52] = 11'($urandom_range(0, 2));
    return d;
  endfunction

  function automatic var_req_t rand_var(input bit last);
    var_req_t v;
    v.kind     = 2'($urandom_range(0, 3));
    v.lo_dist  = rand_dbl();
    v.lo_slack = rand_dbl();
    v.up_dist  = rand_dbl();
    v.up_slack = rand_dbl();
    v.last     = last;
    return v;
  endfunction

  function automatic var_req_t mk_var(input logic [1:0] k, input logic [63:0] a,
                                      input logic [63:0] b, input logic [63:0] c,
                                      input logic [63:0] d, input bit last);
    var_req_t v;
    v.kind = k; v.lo_dist = a; v.lo_slack = b; v.up_dist = c; v.up_slack = d;
    v.last = last;
    return v;
  endfunction

  // input driver: holds a request until accepted, random idle bursts
  always @(posedge clk_i) begin
    bit acc;
    acc = s_axis_tvalid && s_axis_tready;
    if (acc) begin
      predict_gap(pending_vars[0]);
      void'(pending_vars.pop_front());
    end
    if (!s_axis_tvalid || acc) begin
      if (s_idle > 0) begin
        s_idle = s_idle - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        s_idle = $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else if (pending_vars.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_vars[0].up_slack, pending_vars[0].up_dist,
                          pending_vars[0].lo_slack, pending_vars[0].lo_dist};
        s_axis_tuser  <= pending_vars[0].kind;
        s_axis_tlast  <= pending_vars[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    gap_res_t e;
    bit       bad;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_gaps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = expected_gaps.pop_front();
        // a nan sum only has to come out with an all-ones exponent
        if (e.gap[62:52] == 11'h7FF && e.gap[51:0] != 0)
          bad = m_axis_tdata[62:52] != 11'h7FF;
        else
          bad = m_axis_tdata[63:0] != e.gap;
        bad = bad || m_axis_tdata[126:64] != e.worst || m_axis_tdata[127] != e.flag;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp gap %h worst %h flag %b, got gap %h worst %h flag %b",
                     e.gap, e.worst, e.flag, m_axis_tdata[63:0], m_axis_tdata[126:64],
                     m_axis_tdata[127]);
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_idle > 0) begin
      m_idle = m_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_idle = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // wait until every request went in and every result came out
  task automatic drain_all();
    while (pending_vars.size() > 0 || s_axis_tvalid || expected_gaps.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [62:0] t);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr_bits = t;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_runs(input int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) pending_vars.push_back(rand_var(i == len - 1));
      left -= len;
    end
  endtask

  // stimulus sequence
  initial begin
    logic [62:0] thr_set[6];
    thr_set[0] = 63'h3FF0_0000_0000_0000;
    thr_set[1] = 63'h7FF0_0000_0000_0000;
    thr_set[2] = 63'h7FFF_FFFF_FFFF_FFFF;
    thr_set[3] = 63'h0000_0000_0000_0001;
    thr_set[4] = 63'h3FE0_0000_0000_0000;
    thr_set[5] = 63'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset threshold of zero
    pending_vars.push_back(mk_var(KIND_NONE, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                                  64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_BOTH, 64'h4000_0000_0000_0000,
                                  64'h4008_0000_0000_0000,
                                  64'h4000_0000_0000_0000, 64'hC008_0000_0000_0000, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_LOWER, 64'h7FEF_FFFF_FFFF_FFFF,
                                  64'hFFEF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 0));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_UPPER, 64'h0, 64'h0,
                                  64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_BOTH, 64'h8000_0000_0000_0000,
                                  64'h4000_0000_0000_0000,
                                  64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_LOWER, 64'h7FF0_0000_0000_0000,
                                  64'h4000_0000_0000_0000,
                                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_BOTH, 64'h3FF8_0000_0000_0000,
                                  64'h3FF0_0000_0000_0000,
                                  64'h4010_0000_0000_0000, 64'hBFF0_0000_0000_0000, 0));
    pending_vars.push_back(mk_var(KIND_NONE, 64'h0, 64'h0, 64'h0, 64'h0, 0));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_UPPER, 64'h0, 64'h0,
                                  64'h3FE0_0000_0000_0000, 64'h3FE0_0000_0000_0000, 1));
    drain_all();

    // directed: threshold 1.0, products below, at and above it
    write_threshold(63'h3FF0_0000_0000_0000);
    pending_vars.push_back(mk_var(cgr_pkg::KIND_BOTH, 64'h3FF0_0000_0000_0000,
                                  64'h3FF0_0000_0000_0000,
                                  64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_BOTH, 64'h4000_0000_0000_0000,
                                  64'hC000_0000_0000_0000,
                                  64'h4008_0000_0000_0000, 64'h3FF0_0000_0000_0000, 0));
    pending_vars.push_back(mk_var(cgr_pkg::KIND_LOWER, 64'h4014_0000_0000_0000,
                                  64'h3FF0_0000_0000_0000, 64'h0, 64'h0, 1));
    drain_all();

    // random phases across threshold settings, the sender pauses between them
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(ph == 4 ? 63'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF)
                              : thr_set[ph]);
      if (ph == 5) quiet = 1'b1;
      queue_runs(ph == 5 ? 80 : 115);
      drain_all();
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // run limit
  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/cgr_pkg.sv
rtl/core/cgr_ctrl.sv
rtl/core/cgr_dpath.sv
rtl/core/complementarity_gap_reduce_top.sv
bench/tb_complementarity_gap_reduce_top.sv
